FILE: rtl/char_display_shadow_buffer_unit_macros.svh
// ---------------------------------------------------------------------------
// char display shadow buffer assertion macros
// shared concurrent assertion wrappers for the shadow buffer block
// ---------------------------------------------------------------------------
`ifndef CHAR_DISPLAY_SHADOW_BUFFER_UNIT_MACROS_SVH
`define CHAR_DISPLAY_SHADOW_BUFFER_UNIT_MACROS_SVH

// checked only outside reset
`define CDSB_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define CDSB_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: rtl/cdsb_pkg.sv
// ---------------------------------------------------------------------------
// cdsb_pkg
// shared types and constants of the character display shadow buffer
// ---------------------------------------------------------------------------
`default_nettype none

package cdsb_pkg;

  localparam int DEF_ROWS = 4;
  localparam int DEF_COLS = 20;

  localparam int MODE_W = 3;
  localparam int BYTE_W = 8;
  localparam int OROW_W = 2;
  localparam int OCOL_W = 5;

  localparam logic [MODE_W-1:0] MODE_SET_CURSOR = 3'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE_CHAR = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR_ALL  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR_LOW  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REFRESH    = 3'd4;

  localparam logic [BYTE_W-1:0] SPACE_CODE = 8'h20;

  // one result transaction
  typedef struct packed {
    logic              set_cursor;
    logic [OROW_W-1:0] cursor_row;
    logic [OCOL_W-1:0] cursor_col;
    logic              send_char;
    logic [BYTE_W-1:0] char_code;
    logic              last;
  } cdsb_item_t;

  typedef struct packed {
    logic init_busy;
    logic refresh_busy;
  } cdsb_stat_t;

endpackage

`default_nettype wire

FILE: rtl/char_display_shadow_buffer_unit.sv
// set cursor, write char and unused modes: handled at accept, no result
// clear all: fills every frame cell with spaces, clear below top row: fills every cell from row 1 on
// refresh: read then compare per cell of the row, then a flush, plus output stalls
// row-start result waits until the first differing cell is compared, or until the flush
// when no cell differs; last flag added at the flush
// after reset a clearing pass zeroes every cell of both stores, not ready meanwhile
// ---------------------------------------------------------------------------
// char_display_shadow_buffer_unit
// character display frame buffer with shadow copy and row refresh
// ---------------------------------------------------------------------------
`default_nettype none

`include "char_display_shadow_buffer_unit_macros.svh"

module char_display_shadow_buffer_unit
  import cdsb_pkg::*;
#(
  parameter int ROWS = DEF_ROWS,
  parameter int COLS = DEF_COLS
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // input transactions
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [MODE_W-1:0] in_mode_i,
  input  wire logic [BYTE_W-1:0] in_row_i,
  input  wire logic [BYTE_W-1:0] in_col_i,
  input  wire logic [BYTE_W-1:0] in_character_i,
  // result transactions
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   out_set_cursor_o,
  output logic [OROW_W-1:0]      out_cursor_row_o,
  output logic [OCOL_W-1:0]      out_cursor_col_o,
  output logic                   out_send_char_o,
  output logic [BYTE_W-1:0]      out_char_code_o,
  output logic                   out_last_o
);

  logic       out_free;
  logic       push;
  cdsb_item_t push_item;
  cdsb_stat_t stat;
  logic       out_v_q, out_v_d;
  cdsb_item_t out_q;
  logic       refresh_acc;

  // sequencer with both stores; it hands finished results to the output register
  cdsb_ctrl #(.ROWS(ROWS), .COLS(COLS)) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_mode_i      (in_mode_i),
    .in_row_i       (in_row_i),
    .in_col_i       (in_col_i),
    .in_character_i (in_character_i),
    .out_free_i     (out_free),
    .push_o         (push),
    .push_item_o    (push_item),
    .stat_o         (stat)
  );

  // output register: free when empty or being taken this cycle
  assign out_free = !out_v_q || out_ready_i;

  always_comb begin
    out_v_d = out_v_q;
    if (push) begin
      out_v_d = 1'b1;
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (push) begin
      out_q <= push_item;
    end
  end

  assign out_valid_o      = out_v_q;
  assign out_set_cursor_o = out_q.set_cursor;
  assign out_cursor_row_o = out_q.cursor_row;
  assign out_cursor_col_o = out_q.cursor_col;
  assign out_send_char_o  = out_q.send_char;
  assign out_char_code_o  = out_q.char_code;
  assign out_last_o       = out_q.last;

  // in-range refresh taken this cycle
  assign refresh_acc = in_valid_i && in_ready_o && (in_mode_i == MODE_REFRESH) &&
                       (in_row_i < BYTE_W'(ROWS));

  // a result is only pushed into a free output register
  `CDSB_ASSERT(a_push_free, push |-> out_free, "result pushed while output register full")
  // no transaction is taken during the clearing pass
  `CDSB_ASSERT_ALWAYS(a_init_not_ready, stat.init_busy |-> !in_ready_o, "ready during clearing pass")
  // an in-range refresh keeps the sequencer busy in the next cycle
  `CDSB_ASSERT(a_refresh_busy, refresh_acc |=> stat.refresh_busy, "refresh not started")

endmodule

`default_nettype wire

FILE: rtl/cdsb_ram.sv
// ---------------------------------------------------------------------------
// cdsb_ram
// single write port, single registered read port memory
// ---------------------------------------------------------------------------
`default_nettype none

module cdsb_ram #(
  parameter int DEPTH = 80,
  parameter int WIDTH = 8,
  parameter int AW    = 7
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/cdsb_ctrl.sv
// ---------------------------------------------------------------------------
// cdsb_ctrl
// sequencer: cursor, cell index walker, compare unit and pending result
// ---------------------------------------------------------------------------
`default_nettype none

module cdsb_ctrl
  import cdsb_pkg::*;
#(
  parameter int ROWS = DEF_ROWS,
  parameter int COLS = DEF_COLS
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [MODE_W-1:0]    in_mode_i,
  input  wire logic [BYTE_W-1:0]    in_row_i,
  input  wire logic [BYTE_W-1:0]    in_col_i,
  input  wire logic [BYTE_W-1:0]    in_character_i,
  input  wire logic                 out_free_i,
  output logic                      push_o,
  output cdsb_item_t                push_item_o,
  output cdsb_stat_t                stat_o
);

  localparam int CELLS  = ROWS * COLS;
  localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W  = (COLS > 1) ? $clog2(COLS) : 1;

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_FILL  = 3'd2;
  localparam logic [2:0] ST_RD    = 3'd3;
  localparam logic [2:0] ST_CMP   = 3'd4;
  localparam logic [2:0] ST_FLUSH = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [CELL_W-1:0] idx_q, idx_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [BYTE_W-1:0] cur_row_q, cur_row_d;
  logic [BYTE_W-1:0] cur_col_q, cur_col_d;
  logic              prev_sent_q, prev_sent_d;
  cdsb_item_t        pend_q, pend_d;

  logic              fr_we, sh_we;
  logic [CELL_W-1:0] fr_waddr;
  logic [BYTE_W-1:0] fr_wdata, sh_wdata;
  logic [BYTE_W-1:0] fr_rdata, sh_rdata;
  logic              accept;
  logic              cur_in_range;
  logic [CELL_W-1:0] cur_addr;

  cdsb_ram #(.DEPTH(CELLS), .WIDTH(BYTE_W), .AW(CELL_W)) u_frame (
    .clk_i   (clk_i),
    .we_i    (fr_we),
    .waddr_i (fr_waddr),
    .wdata_i (fr_wdata),
    .raddr_i (idx_q),
    .rdata_o (fr_rdata)
  );

  cdsb_ram #(.DEPTH(CELLS), .WIDTH(BYTE_W), .AW(CELL_W)) u_shadow (
    .clk_i   (clk_i),
    .we_i    (sh_we),
    .waddr_i (idx_q),
    .wdata_i (sh_wdata),
    .raddr_i (idx_q),
    .rdata_o (sh_rdata)
  );

  assign accept       = in_valid_i && in_ready_o;
  assign in_ready_o   = (state_q == ST_IDLE);
  assign cur_in_range = (cur_row_q < BYTE_W'(ROWS)) && (cur_col_q < BYTE_W'(COLS));
  assign cur_addr     = CELL_W'(int'(cur_row_q[ROW_W-1:0]) * COLS
                                + int'(cur_col_q[COL_W-1:0]));

  assign stat_o.init_busy    = (state_q == ST_INIT);
  assign stat_o.refresh_busy = (state_q == ST_RD) || (state_q == ST_CMP) ||
                               (state_q == ST_FLUSH);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    col_d       = col_q;
    row_d       = row_q;
    cur_row_d   = cur_row_q;
    cur_col_d   = cur_col_q;
    prev_sent_d = prev_sent_q;
    pend_d      = pend_q;
    fr_we       = 1'b0;
    fr_waddr    = idx_q;
    fr_wdata    = SPACE_CODE;
    sh_we       = 1'b0;
    sh_wdata    = fr_rdata;
    push_o      = 1'b0;
    push_item_o = pend_q;

    unique case (state_q)
      ST_INIT: begin
        // clearing pass: both stores to zero
        fr_we    = 1'b1;
        fr_wdata = '0;
        sh_we    = 1'b1;
        sh_wdata = '0;
        if (idx_q == CELL_W'(CELLS - 1)) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (in_mode_i)
            MODE_SET_CURSOR: begin
              cur_row_d = in_row_i;
              cur_col_d = in_col_i;
            end
            MODE_WRITE_CHAR: begin
              if (cur_in_range) begin
                fr_we    = 1'b1;
                fr_waddr = cur_addr;
                fr_wdata = in_character_i;
                if (cur_col_q == BYTE_W'(COLS - 1)) begin
                  cur_col_d = '0;
                  cur_row_d = (cur_row_q == BYTE_W'(ROWS - 1)) ? '0 : cur_row_q + 1'b1;
                end else begin
                  cur_col_d = cur_col_q + 1'b1;
                end
              end
            end
            MODE_CLEAR_ALL: begin
              cur_row_d = '0;
              cur_col_d = '0;
              idx_d     = '0;
              state_d   = ST_FILL;
            end
            MODE_CLEAR_LOW: begin
              cur_row_d = '0;
              cur_col_d = '0;
              if (ROWS > 1) begin
                idx_d   = CELL_W'(COLS);
                state_d = ST_FILL;
              end
            end
            MODE_REFRESH: begin
              if (in_row_i < BYTE_W'(ROWS)) begin
                row_d  = in_row_i[ROW_W-1:0];
                col_d  = '0;
                idx_d  = CELL_W'(int'(in_row_i[ROW_W-1:0]) * COLS);
                // row-start cursor move waits as pending result
                pend_d = '{set_cursor: 1'b1, cursor_row: in_row_i[OROW_W-1:0],
                           cursor_col: '0, send_char: 1'b0, char_code: '0,
                           last: 1'b0};
                state_d = ST_RD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FILL: begin
        fr_we = 1'b1;
        if (idx_q == CELL_W'(CELLS - 1)) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_RD: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if ((fr_rdata == sh_rdata) || out_free_i) begin
          if (fr_rdata != sh_rdata) begin
            push_o      = 1'b1;
            sh_we       = 1'b1;
            prev_sent_d = 1'b1;
            pend_d = '{set_cursor: !prev_sent_q, cursor_row: OROW_W'(row_q),
                       cursor_col: OCOL_W'(col_q), send_char: 1'b1,
                       char_code: fr_rdata, last: 1'b0};
          end else begin
            prev_sent_d = 1'b0;
          end
          if (col_q == COL_W'(COLS - 1)) begin
            state_d = ST_FLUSH;
          end else begin
            col_d   = col_q + 1'b1;
            idx_d   = idx_q + 1'b1;
            state_d = ST_RD;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free_i) begin
          push_o           = 1'b1;
          push_item_o.last = 1'b1;
          idx_d            = '0;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      idx_q       <= '0;
      cur_row_q   <= '0;
      cur_col_q   <= '0;
      prev_sent_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cur_row_q   <= cur_row_d;
      cur_col_q   <= cur_col_d;
      prev_sent_q <= prev_sent_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q  <= col_d;
    row_q  <= row_d;
    pend_q <= pend_d;
  end

endmodule

`default_nettype wire
